// ===== rtl/core/pdbc_pkg.sv =====
package pdbc_pkg;

    // Reset value of the frame start byte
    localparam logic [7:0] HEADER_RESET = 8'hCC;

    // Input opcodes
    typedef enum logic [1:0] {
        OP_RECEIVE = 2'd0,
        OP_READ    = 2'd1,
        OP_RELEASE = 2'd2,
        OP_IGNORE  = 2'd3
    } op_t;

    // Result kinds
    typedef enum logic [2:0] {
        KIND_QUEUED   = 3'd0,
        KIND_FAIL     = 3'd1,
        KIND_DROPPED  = 3'd2,
        KIND_READ     = 3'd3,
        KIND_EMPTY    = 3'd4,
        KIND_RELEASED = 3'd5
    } kind_t;

    // Parser states
    typedef enum logic [2:0] {
        PS_STANDBY,
        PS_LEN,
        PS_ID,
        PS_PAYLOAD,
        PS_CHECKSUM
    } parse_state_t;

    // Commands handed from the parser to the ring engine
    typedef enum logic [2:0] {
        CMD_STORE,
        CMD_GOOD,
        CMD_BAD,
        CMD_READ,
        CMD_RELEASE
    } cmd_op_t;

    typedef struct packed {
        cmd_op_t    op;
        logic [7:0] data;   // payload byte for a store
        logic [7:0] index;  // payload offset for a store or a read
        logic [7:0] id;     // frame id for a finished frame
        logic [7:0] len;    // frame length for a finished frame
    } cmd_t;

    // One BSD checksum step: rotate right by one, then add
    function automatic logic [7:0] bsd_step(input logic [7:0] sum, input logic [7:0] b);
        bsd_step = {sum[0], sum[7:1]} + b;
    endfunction

    // True when index lies inside the stored payload of a frame of length len
    function automatic logic in_payload(input logic [7:0] index, input logic [7:0] len);
        in_payload = ({1'b0, index} + 9'd1) < {1'b0, len};
    endfunction

endpackage

// ===== rtl/core/packet_deframer_bsd_checksum_top.sv =====
// Channel   Direction  Handshake            Payload
// cfg       in         cfg_valid/cfg_ready  cfg_data (frame start byte)
// s         in         s_valid/s_ready      s_opcode, s_rx_byte, s_read_index
// m         out        m_valid/m_ready      m_kind, m_packet_id, m_packet_len,
//                                           m_data_byte, m_queue_count
//
// Sustained rate is one word per cycle while the command queue has room; a word passes the
// parser, a command queue entry, then the ring engine loading the result register and packet memory read.
// A two-entry command queue between parser and ring engine keeps s_ready high while the
// result register drains; s_ready drops only when the queue is full.
// The packet and slot memories need no clearing.
module packet_deframer_bsd_checksum_top #(
    parameter int QUEUE_SLOTS = 8,
    parameter int MAX_PAYLOAD = 256
) (
    input  logic       aclk,
    input  logic       aresetn,
    input  logic       cfg_valid,
    output logic       cfg_ready,
    input  logic [7:0] cfg_data,
    input  logic       s_valid,
    output logic       s_ready,
    input  logic [1:0] s_opcode,
    input  logic [7:0] s_rx_byte,
    input  logic [7:0] s_read_index,
    output logic       m_valid,
    input  logic       m_ready,
    output logic [2:0] m_kind,
    output logic [7:0] m_packet_id,
    output logic [7:0] m_packet_len,
    output logic [7:0] m_data_byte,
    output logic [2:0] m_queue_count
);

    import pdbc_pkg::*;

    logic fifo_full, push, pop, head_valid;
    cmd_t push_cmd, head_cmd;

    pdbc_front #(
        .MAX_PAYLOAD (MAX_PAYLOAD)
    ) u_front (
        .aclk         (aclk),
        .aresetn      (aresetn),
        .cfg_valid    (cfg_valid),
        .cfg_ready    (cfg_ready),
        .cfg_data     (cfg_data),
        .s_valid      (s_valid),
        .s_ready      (s_ready),
        .s_opcode     (s_opcode),
        .s_rx_byte    (s_rx_byte),
        .s_read_index (s_read_index),
        .fifo_full    (fifo_full),
        .push         (push),
        .push_cmd     (push_cmd)
    );

    pdbc_cmd_fifo u_cmd_fifo (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .push       (push),
        .push_cmd   (push_cmd),
        .full       (fifo_full),
        .pop        (pop),
        .head_valid (head_valid),
        .head_cmd   (head_cmd)
    );

    pdbc_back #(
        .QUEUE_SLOTS (QUEUE_SLOTS),
        .MAX_PAYLOAD (MAX_PAYLOAD)
    ) u_back (
        .aclk          (aclk),
        .aresetn       (aresetn),
        .head_valid    (head_valid),
        .head_cmd      (head_cmd),
        .pop           (pop),
        .m_valid       (m_valid),
        .m_ready       (m_ready),
        .m_kind        (m_kind),
        .m_packet_id   (m_packet_id),
        .m_packet_len  (m_packet_len),
        .m_data_byte   (m_data_byte),
        .m_queue_count (m_queue_count)
    );

endmodule

// ===== rtl/core/pdbc_ram.sv =====
module pdbc_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 2048
) (
    input  logic                     aclk,
    input  logic                     wr_en,
    input  logic [$clog2(DEPTH)-1:0] wr_addr,
    input  logic [WIDTH-1:0]         wr_data,
    input  logic                     rd_en,
    input  logic [$clog2(DEPTH)-1:0] rd_addr,
    output logic [WIDTH-1:0]         rd_data
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rd_data_reg;

    // Write port, registered read port (old data on collision)
    always_ff @(posedge aclk) begin
        if (wr_en) begin
            mem[wr_addr] <= wr_data;
        end
        if (rd_en) begin
            rd_data_reg <= mem[rd_addr];
        end
    end

    assign rd_data = rd_data_reg;

endmodule

// ===== rtl/core/pdbc_cmd_fifo.sv =====
module pdbc_cmd_fifo (
    input  logic           aclk,
    input  logic           aresetn,
    input  logic           push,
    input  pdbc_pkg::cmd_t push_cmd,
    output logic           full,
    input  logic           pop,
    output logic           head_valid,
    output pdbc_pkg::cmd_t head_cmd
);

    import pdbc_pkg::*;

    cmd_t       entry_reg [2];
    logic       wr_ptr_reg, wr_ptr_next;
    logic       rd_ptr_reg, rd_ptr_next;
    logic [1:0] count_reg, count_next;

    // Advance pointers and occupancy
    always_comb begin
        wr_ptr_next = push ? ~wr_ptr_reg : wr_ptr_reg;
        rd_ptr_next = pop ? ~rd_ptr_reg : rd_ptr_reg;
        count_next  = count_reg + {1'b0, push} - {1'b0, pop};
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= 1'b0;
            rd_ptr_reg <= 1'b0;
            count_reg  <= 2'd0;
        end else begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    // Hold entries until popped
    always_ff @(posedge aclk) begin
        if (push) begin
            entry_reg[wr_ptr_reg] <= push_cmd;
        end
    end

    assign full       = (count_reg == 2'd2);
    assign head_valid = (count_reg != 2'd0);
    assign head_cmd   = entry_reg[rd_ptr_reg];

endmodule

// ===== rtl/core/pdbc_front.sv =====
module pdbc_front #(
    parameter int MAX_PAYLOAD = 256
) (
    input  logic           aclk,
    input  logic           aresetn,
    input  logic           cfg_valid,
    output logic           cfg_ready,
    input  logic [7:0]     cfg_data,
    input  logic           s_valid,
    output logic           s_ready,
    input  logic [1:0]     s_opcode,
    input  logic [7:0]     s_rx_byte,
    input  logic [7:0]     s_read_index,
    input  logic           fifo_full,
    output logic           push,
    output pdbc_pkg::cmd_t push_cmd
);

    import pdbc_pkg::*;

    parse_state_t state_reg, state_next;
    logic [7:0]   header_reg;
    logic [7:0]   count_reg, count_next;
    logic [7:0]   sum_reg, sum_next;
    logic [7:0]   len_reg, len_next;
    logic [7:0]   id_reg, id_next;
    logic         accept;

    assign cfg_ready = 1'b1;
    assign s_ready   = !fifo_full;
    assign accept    = s_valid && s_ready;

    // Classify the word and step the frame parser
    always_comb begin
        state_next = state_reg;
        count_next = count_reg;
        sum_next   = sum_reg;
        len_next   = len_reg;
        id_next    = id_reg;
        push       = 1'b0;
        push_cmd   = '{op: CMD_STORE, data: s_rx_byte, index: count_reg,
                       id: id_reg, len: len_reg};
        if (accept) begin
            unique case (op_t'(s_opcode))
                OP_RECEIVE: begin
                    unique case (state_reg)
                        PS_STANDBY: begin
                            if (s_rx_byte == header_reg) begin
                                count_next = 8'd0;
                                state_next = PS_LEN;
                            end
                        end
                        PS_LEN: begin
                            len_next   = s_rx_byte;
                            state_next = PS_ID;
                        end
                        PS_ID: begin
                            id_next    = s_rx_byte;
                            sum_next   = bsd_step(sum_reg, s_rx_byte);
                            state_next = PS_PAYLOAD;
                        end
                        PS_PAYLOAD: begin
                            if (in_payload(count_reg, len_reg)) begin
                                push       = ({1'b0, count_reg} < 9'(MAX_PAYLOAD));
                                sum_next   = bsd_step(sum_reg, s_rx_byte);
                                count_next = count_reg + 8'd1;
                            end else begin
                                // trailer byte, skip it
                                state_next = PS_CHECKSUM;
                            end
                        end
                        PS_CHECKSUM: begin
                            push        = 1'b1;
                            push_cmd.op = (s_rx_byte == sum_reg) ? CMD_GOOD : CMD_BAD;
                            sum_next    = 8'd0;
                            state_next  = PS_STANDBY;
                        end
                        default: begin
                            state_next = PS_STANDBY;
                        end
                    endcase
                end
                OP_READ: begin
                    push           = 1'b1;
                    push_cmd.op    = CMD_READ;
                    push_cmd.index = s_read_index;
                end
                OP_RELEASE: begin
                    push        = 1'b1;
                    push_cmd.op = CMD_RELEASE;
                end
                OP_IGNORE: begin
                    push = 1'b0;
                end
                default: begin
                    push = 1'b0;
                end
            endcase
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg  <= PS_STANDBY;
            header_reg <= HEADER_RESET;
            count_reg  <= 8'd0;
            sum_reg    <= 8'd0;
            len_reg    <= 8'd0;
            id_reg     <= 8'd0;
        end else begin
            state_reg <= state_next;
            count_reg <= count_next;
            sum_reg   <= sum_next;
            len_reg   <= len_next;
            id_reg    <= id_next;
            if (cfg_valid && cfg_ready) begin
                header_reg <= cfg_data;
            end
        end
    end

endmodule

// ===== rtl/core/pdbc_back.sv =====
module pdbc_back #(
    parameter int QUEUE_SLOTS = 8,
    parameter int MAX_PAYLOAD = 256
) (
    input  logic           aclk,
    input  logic           aresetn,
    input  logic           head_valid,
    input  pdbc_pkg::cmd_t head_cmd,
    output logic           pop,
    output logic           m_valid,
    input  logic           m_ready,
    output logic [2:0]     m_kind,
    output logic [7:0]     m_packet_id,
    output logic [7:0]     m_packet_len,
    output logic [7:0]     m_data_byte,
    output logic [2:0]     m_queue_count
);

    import pdbc_pkg::*;

    localparam int SLOT_W = $clog2(QUEUE_SLOTS);
    localparam int DEPTH  = QUEUE_SLOTS * MAX_PAYLOAD;
    localparam int ADDR_W = $clog2(DEPTH);
    localparam int CNT_W  = SLOT_W + 3;
    localparam logic [SLOT_W-1:0] LAST_SLOT = SLOT_W'(QUEUE_SLOTS - 1);
    localparam logic [ADDR_W-1:0] SLOT_SPAN = ADDR_W'(MAX_PAYLOAD);

    logic [SLOT_W-1:0] wslot_reg, wslot_next, wslot_inc;
    logic [SLOT_W-1:0] rslot_reg, rslot_next, rslot_inc;
    logic [ADDR_W-1:0] wbase_reg, wbase_next, wbase_inc;
    logic [ADDR_W-1:0] rbase_reg, rbase_next, rbase_inc;
    logic              empty, full, needs_out, out_free, fire;
    logic [CNT_W-1:0]  waiting;

    // Packet store ports
    logic              pkt_wr_en, pkt_rd_en;
    logic [ADDR_W-1:0] pkt_wr_addr, pkt_rd_addr;
    logic [7:0]        pkt_rd_data;

    // Slot id/len store ports, read continuously at the head slot
    logic              meta_wr_en;
    logic [15:0]       meta_rd_data;
    logic              bypass_reg, bypass_next;
    logic [15:0]       bypass_data_reg;
    logic [7:0]        head_id, head_len;

    // Result register
    logic              out_valid_reg;
    kind_t             kind_reg, kind_next;
    logic [7:0]        id_reg, id_next;
    logic [7:0]        len_reg, len_next;
    logic [2:0]        qcount_reg, qcount_next;
    logic              data_sel_reg, data_sel_next;

    assign empty     = (wslot_reg == rslot_reg);
    assign wslot_inc = (wslot_reg == LAST_SLOT) ? '0 : wslot_reg + SLOT_W'(1);
    assign rslot_inc = (rslot_reg == LAST_SLOT) ? '0 : rslot_reg + SLOT_W'(1);
    assign wbase_inc = (wslot_reg == LAST_SLOT) ? '0 : wbase_reg + SLOT_SPAN;
    assign rbase_inc = (rslot_reg == LAST_SLOT) ? '0 : rbase_reg + SLOT_SPAN;
    assign full      = (wslot_inc == rslot_reg);

    assign head_id  = bypass_reg ? bypass_data_reg[15:8] : meta_rd_data[15:8];
    assign head_len = bypass_reg ? bypass_data_reg[7:0]  : meta_rd_data[7:0];

    // Issue the head command when its result has somewhere to go
    assign needs_out = (head_cmd.op != CMD_STORE);
    assign out_free  = !out_valid_reg || m_ready;
    assign fire      = head_valid && (!needs_out || out_free);
    assign pop       = fire;

    // Carry out the command
    always_comb begin
        wslot_next    = wslot_reg;
        rslot_next    = rslot_reg;
        wbase_next    = wbase_reg;
        rbase_next    = rbase_reg;
        pkt_wr_en     = 1'b0;
        pkt_rd_en     = 1'b0;
        pkt_wr_addr   = wbase_reg + ADDR_W'(head_cmd.index);
        pkt_rd_addr   = rbase_reg + ADDR_W'(head_cmd.index);
        meta_wr_en    = 1'b0;
        kind_next     = KIND_EMPTY;
        id_next       = 8'd0;
        len_next      = 8'd0;
        data_sel_next = 1'b0;
        if (fire) begin
            case (head_cmd.op)
                CMD_STORE: begin
                    pkt_wr_en = 1'b1;
                end
                CMD_GOOD: begin
                    id_next  = head_cmd.id;
                    len_next = head_cmd.len;
                    if (full) begin
                        kind_next = KIND_DROPPED;
                    end else begin
                        kind_next  = KIND_QUEUED;
                        meta_wr_en = 1'b1;
                        wslot_next = wslot_inc;
                        wbase_next = wbase_inc;
                    end
                end
                CMD_BAD: begin
                    kind_next = KIND_FAIL;
                    id_next   = head_cmd.id;
                    len_next  = head_cmd.len;
                end
                CMD_READ: begin
                    if (!empty) begin
                        kind_next = KIND_READ;
                        id_next   = head_id;
                        len_next  = head_len;
                        if (in_payload(head_cmd.index, head_len) &&
                            ({1'b0, head_cmd.index} < 9'(MAX_PAYLOAD))) begin
                            pkt_rd_en     = 1'b1;
                            data_sel_next = 1'b1;
                        end
                    end
                end
                CMD_RELEASE: begin
                    if (!empty) begin
                        kind_next  = KIND_RELEASED;
                        id_next    = head_id;
                        len_next   = head_len;
                        rslot_next = rslot_inc;
                        rbase_next = rbase_inc;
                    end
                end
                default: begin
                    kind_next = KIND_EMPTY;
                end
            endcase
        end
    end

    // Packets waiting after this command, modulo eight
    always_comb begin
        if (wslot_next >= rslot_next) begin
            waiting = CNT_W'(wslot_next) - CNT_W'(rslot_next);
        end else begin
            waiting = CNT_W'(wslot_next) + CNT_W'(QUEUE_SLOTS) - CNT_W'(rslot_next);
        end
        qcount_next = waiting[2:0];
    end

    // Forward a slot written in the same cycle it is read
    assign bypass_next = meta_wr_en && (wslot_reg == rslot_next);

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wslot_reg     <= '0;
            rslot_reg     <= '0;
            wbase_reg     <= '0;
            rbase_reg     <= '0;
            bypass_reg    <= 1'b0;
            out_valid_reg <= 1'b0;
        end else begin
            wslot_reg  <= wslot_next;
            rslot_reg  <= rslot_next;
            wbase_reg  <= wbase_next;
            rbase_reg  <= rbase_next;
            bypass_reg <= bypass_next;
            if (fire && needs_out) begin
                out_valid_reg <= 1'b1;
            end else if (m_ready) begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    // Hold the result fields until the next result loads
    always_ff @(posedge aclk) begin
        bypass_data_reg <= {head_cmd.id, head_cmd.len};
        if (fire && needs_out) begin
            kind_reg     <= kind_next;
            id_reg       <= id_next;
            len_reg      <= len_next;
            qcount_reg   <= qcount_next;
            data_sel_reg <= data_sel_next;
        end
    end

    pdbc_ram #(
        .WIDTH (8),
        .DEPTH (DEPTH)
    ) u_packet_ram (
        .aclk    (aclk),
        .wr_en   (pkt_wr_en),
        .wr_addr (pkt_wr_addr),
        .wr_data (head_cmd.data),
        .rd_en   (pkt_rd_en),
        .rd_addr (pkt_rd_addr),
        .rd_data (pkt_rd_data)
    );

    pdbc_ram #(
        .WIDTH (16),
        .DEPTH (QUEUE_SLOTS)
    ) u_slot_ram (
        .aclk    (aclk),
        .wr_en   (meta_wr_en),
        .wr_addr (wslot_reg),
        .wr_data ({head_cmd.id, head_cmd.len}),
        .rd_en   (1'b1),
        .rd_addr (rslot_next),
        .rd_data (meta_rd_data)
    );

    assign m_valid       = out_valid_reg;
    assign m_kind        = kind_reg;
    assign m_packet_id   = id_reg;
    assign m_packet_len  = len_reg;
    assign m_data_byte   = data_sel_reg ? pkt_rd_data : 8'd0;
    assign m_queue_count = qcount_reg;

endmodule

// ===== sim/testbench.sv =====
module testbench;
    timeunit 1ns;
    timeprecision 1ps;

    import pdbc_pkg::*;

    localparam int QUEUE_SLOTS  = 8;
    localparam int MAX_PAYLOAD  = 256;
    localparam int CYCLE_LIMIT  = 1000000;
    localparam int SETTLE_LIMIT = 5000;
    localparam int IDLE_CYCLES  = 8;
    localparam int PHASES       = 8;
    localparam int PHASE_WORDS  = 200;
    localparam int PRINT_LIMIT  = 40;

    // How the byte sent as a checksum is chosen
    typedef enum logic [1:0] {
        CSUM_KEEP,
        CSUM_GOOD,
        CSUM_BAD
    } csum_mode_t;

    typedef struct packed {
        kind_t      kind;
        logic [7:0] id;
        logic [7:0] len;
        logic [7:0] data;
        logic [2:0] count;
    } deframe_result_t;

    typedef struct packed {
        op_t             op;
        logic [7:0]      rx;
        logic [7:0]      idx;
        csum_mode_t      csum;
        logic            typed;     // expected result written in the row
        logic            has_res;   // the row causes a result
        deframe_result_t res;
    } stim_row_t;

    localparam deframe_result_t NONE_RES  = '{KIND_QUEUED, 8'h00, 8'h00, 8'h00, 3'd0};
    localparam deframe_result_t EMPTY_RES = '{KIND_EMPTY, 8'h00, 8'h00, 8'h00, 3'd0};

    logic       aclk;
    logic       aresetn;
    logic       cfg_valid;
    logic       cfg_ready;
    logic [7:0] cfg_data;
    logic       s_valid;
    logic       s_ready;
    logic [1:0] s_opcode;
    logic [7:0] s_rx_byte;
    logic [7:0] s_read_index;
    logic       m_valid;
    logic       m_ready;
    logic [2:0] m_kind;
    logic [7:0] m_packet_id;
    logic [7:0] m_packet_len;
    logic [7:0] m_data_byte;
    logic [2:0] m_queue_count;

    // Shadow copy of the deframer and its ring
    logic [7:0]   start_byte;
    parse_state_t parse_phase;
    int           bytes_in;
    logic [7:0]   sum_acc;
    logic [7:0]   cur_len;
    logic [7:0]   cur_id;
    logic [7:0]   payload_mem [QUEUE_SLOTS * MAX_PAYLOAD];
    logic [7:0]   ring_len [QUEUE_SLOTS];
    logic [7:0]   ring_id [QUEUE_SLOTS];
    int           fill_slot;
    int           drain_slot;

    deframe_result_t awaited_results[$];
    stim_row_t       directed_rows[$];
    int              mismatch_count;
    int              cycle_count;
    int              word_count;
    int              release_pct;
    bit              quiet_run;

    packet_deframer_bsd_checksum_top #(
        .QUEUE_SLOTS(QUEUE_SLOTS),
        .MAX_PAYLOAD(MAX_PAYLOAD)
    ) dut (
        .aclk         (aclk),
        .aresetn      (aresetn),
        .cfg_valid    (cfg_valid),
        .cfg_ready    (cfg_ready),
        .cfg_data     (cfg_data),
        .s_valid      (s_valid),
        .s_ready      (s_ready),
        .s_opcode     (s_opcode),
        .s_rx_byte    (s_rx_byte),
        .s_read_index (s_read_index),
        .m_valid      (m_valid),
        .m_ready      (m_ready),
        .m_kind       (m_kind),
        .m_packet_id  (m_packet_id),
        .m_packet_len (m_packet_len),
        .m_data_byte  (m_data_byte),
        .m_queue_count(m_queue_count)
    );

    initial begin
        aclk = 1'b0;
        forever #5 aclk = ~aclk;
    end

    task automatic report_mismatch(input string msg);
        mismatch_count++;
        if (mismatch_count <= PRINT_LIMIT) begin
            $display("mismatch at cycle %0d: %s", cycle_count, msg);
        end
    endtask

    // Advance the shadow deframer by one word and form the result it causes
    task automatic advance_deframer(input op_t op, input logic [7:0] rx, input logic [7:0] idx,
                                    output bit made, output deframe_result_t res);
        int need;
        made = 1'b0;
        res  = NONE_RES;
        case (op) inside
            OP_RECEIVE: begin
                case (parse_phase)
                    PS_STANDBY: begin
                        if (rx == start_byte) begin
                            bytes_in    = 0;
                            parse_phase = PS_LEN;
                        end
                    end
                    PS_LEN: begin
                        cur_len     = rx;
                        parse_phase = PS_ID;
                    end
                    PS_ID: begin
                        cur_id      = rx;
                        sum_acc     = {sum_acc[0], sum_acc[7:1]} + rx;
                        parse_phase = PS_PAYLOAD;
                    end
                    PS_PAYLOAD: begin
                        need = (cur_len == 8'd0) ? 0 : int'(cur_len) - 1;
                        if (bytes_in < need) begin
                            if (bytes_in < MAX_PAYLOAD) begin
                                payload_mem[fill_slot * MAX_PAYLOAD + bytes_in] = rx;
                            end
                            sum_acc  = {sum_acc[0], sum_acc[7:1]} + rx;
                            bytes_in = (bytes_in + 1) & 255;
                        end else begin
                            // trailer byte: skip it
                            parse_phase = PS_CHECKSUM;
                        end
                    end
                    PS_CHECKSUM: begin
                        made        = 1'b1;
                        res.id      = cur_id;
                        res.len     = cur_len;
                        parse_phase = PS_STANDBY;
                        if (rx != sum_acc) begin
                            res.kind = KIND_FAIL;
                        end else if ((fill_slot + 1) % QUEUE_SLOTS == drain_slot) begin
                            res.kind = KIND_DROPPED;
                        end else begin
                            ring_len[fill_slot] = cur_len;
                            ring_id[fill_slot]  = cur_id;
                            fill_slot           = (fill_slot + 1) % QUEUE_SLOTS;
                            res.kind            = KIND_QUEUED;
                        end
                        sum_acc = 8'h00;
                    end
                    default: begin
                        parse_phase = PS_STANDBY;
                    end
                endcase
            end
            OP_READ, OP_RELEASE: begin
                made = 1'b1;
                if (fill_slot == drain_slot) begin
                    res.kind = KIND_EMPTY;
                end else begin
                    res.id  = ring_id[drain_slot];
                    res.len = ring_len[drain_slot];
                    if (op == OP_READ) begin
                        need     = (res.len == 8'd0) ? 0 : int'(res.len) - 1;
                        res.kind = KIND_READ;
                        if (int'(idx) < need && int'(idx) < MAX_PAYLOAD) begin
                            res.data = payload_mem[drain_slot * MAX_PAYLOAD + int'(idx)];
                        end
                    end else begin
                        res.kind   = KIND_RELEASED;
                        drain_slot = (drain_slot + 1) % QUEUE_SLOTS;
                    end
                end
            end
            default: begin
            end
        endcase
        if (made) begin
            res.count = 3'((fill_slot + QUEUE_SLOTS - drain_slot) % QUEUE_SLOTS);
        end
    endtask

    // Offer one word, hold it until taken, then log what it should produce
    task automatic send_word(input op_t op, input logic [7:0] rx, input logic [7:0] idx,
                             input csum_mode_t csum, input bit typed, input bit typed_has,
                             input deframe_result_t typed_res);
        int              gap;
        logic [7:0]      byte_out;
        bit              made;
        deframe_result_t res;
        gap = quiet_run ? 0 : $urandom_range(0, 18);
        @(negedge aclk);
        if (gap > 0) begin
            s_valid <= 1'b0;
            repeat (gap) @(negedge aclk);
        end
        case (csum)
            CSUM_GOOD: byte_out = sum_acc;
            CSUM_BAD:  byte_out = sum_acc ^ (8'h01 << $urandom_range(0, 7));
            default:   byte_out = rx;
        endcase
        s_opcode     <= op;
        s_rx_byte    <= byte_out;
        s_read_index <= idx;
        s_valid      <= 1'b1;
        do @(posedge aclk); while (!s_ready);
        advance_deframer(op, byte_out, idx, made, res);
        if (typed) begin
            made = typed_has;
            res  = typed_res;
        end
        if (made) begin
            awaited_results.push_back(res);
        end
        if (op != OP_IGNORE) begin
            word_count++;
        end
    endtask

    // Read or release the oldest packet
    task automatic send_command();
        op_t        op;
        logic [7:0] idx;
        op  = ($urandom_range(0, 99) < release_pct) ? OP_RELEASE : OP_READ;
        idx = $urandom_range(0, 1) ? 8'($urandom_range(0, 10)) : 8'($urandom_range(0, 255));
        send_word(op, 8'($urandom_range(0, 255)), idx, CSUM_KEEP, 1'b0, 1'b0, NONE_RES);
    endtask

    // Stop sending, wait for every awaited result, then let the pipeline go quiet
    task automatic settle_results();
        int waited;
        waited = 0;
        @(negedge aclk);
        s_valid <= 1'b0;
        while (awaited_results.size() != 0 && waited < SETTLE_LIMIT) begin
            @(posedge aclk);
            waited++;
        end
        repeat (IDLE_CYCLES) @(negedge aclk);
    endtask

    // Result side: draw a stall before each result, then take it
    initial begin
        int stall;
        m_ready = 1'b0;
        wait (aresetn === 1'b1);
        forever begin
            stall = quiet_run ? 0 : $urandom_range(0, 18);
            @(negedge aclk);
            if (stall > 0) begin
                m_ready <= 1'b0;
                repeat (stall) @(negedge aclk);
            end
            m_ready <= 1'b1;
            do @(posedge aclk); while (!m_valid);
        end
    end

    // Compare each accepted result with the oldest awaited one
    always @(posedge aclk) begin
        deframe_result_t want;
        if (aresetn && m_valid && m_ready) begin
            if (awaited_results.size() == 0) begin
                report_mismatch($sformatf("unexpected result kind %0d id %02h",
                                          m_kind, m_packet_id));
            end else begin
                want = awaited_results.pop_front();
                if (m_kind !== want.kind) begin
                    report_mismatch($sformatf("kind %0d, want %0d", m_kind, want.kind));
                end
                if (m_packet_id !== want.id) begin
                    report_mismatch($sformatf("packet_id %02h, want %02h", m_packet_id, want.id));
                end
                if (m_packet_len !== want.len) begin
                    report_mismatch($sformatf("packet_len %02h, want %02h",
                                              m_packet_len, want.len));
                end
                if (m_data_byte !== want.data) begin
                    report_mismatch($sformatf("data_byte %02h, want %02h",
                                              m_data_byte, want.data));
                end
                if (m_queue_count !== want.count) begin
                    report_mismatch($sformatf("queue_count %0d, want %0d",
                                              m_queue_count, want.count));
                end
            end
        end
    end

    // Watchdog
    initial begin
        cycle_count = 0;
        while (cycle_count < CYCLE_LIMIT) begin
            @(posedge aclk);
            cycle_count++;
        end
        $display("Some tests failed");
        $finish;
    end

    initial begin
        int         phase;
        int         goal;
        int         pick;
        int         len_pick;
        int         flen;
        int         cut;
        logic [7:0] next_start;
        logic [7:0] frame_bytes[$];
        stim_row_t  row;

        aresetn        = 1'b0;
        cfg_valid      = 1'b0;
        cfg_data       = 8'h00;
        s_valid        = 1'b0;
        s_opcode       = OP_RECEIVE;
        s_rx_byte      = 8'h00;
        s_read_index   = 8'h00;
        quiet_run      = 1'b0;
        release_pct    = 45;
        word_count     = 0;
        mismatch_count = 0;

        start_byte  = HEADER_RESET;
        parse_phase = PS_STANDBY;
        bytes_in    = 0;
        sum_acc     = 8'h00;
        cur_len     = 8'h00;
        cur_id      = 8'h00;
        fill_slot   = 0;
        drain_slot  = 0;

        directed_rows = '{
            // empty ring, ignored opcode
            '{OP_READ,    8'h00, 8'h00, CSUM_KEEP, 1'b1, 1'b1, EMPTY_RES},
            '{OP_RELEASE, 8'hFF, 8'hFF, CSUM_KEEP, 1'b1, 1'b1, EMPTY_RES},
            '{OP_IGNORE,  8'hFF, 8'hFF, CSUM_KEEP, 1'b1, 1'b0, NONE_RES},
            // zero length frame, id 0: checksum stays 0
            '{OP_RECEIVE, HEADER_RESET, 8'h00, CSUM_KEEP, 1'b0, 1'b0, NONE_RES},
            '{OP_RECEIVE, 8'h00, 8'h00, CSUM_KEEP, 1'b0, 1'b0, NONE_RES},
            '{OP_RECEIVE, 8'h00, 8'h00, CSUM_KEEP, 1'b0, 1'b0, NONE_RES},
            '{OP_RECEIVE, 8'hFF, 8'h00, CSUM_KEEP, 1'b0, 1'b0, NONE_RES},
            '{OP_RECEIVE, 8'h00, 8'h00, CSUM_KEEP, 1'b1, 1'b1,
              '{KIND_QUEUED, 8'h00, 8'h00, 8'h00, 3'd1}},
            // reads past the stored payload return zero
            '{OP_READ, 8'h00, 8'h00, CSUM_KEEP, 1'b1, 1'b1,
              '{KIND_READ, 8'h00, 8'h00, 8'h00, 3'd1}},
            '{OP_READ, 8'h00, 8'hFF, CSUM_KEEP, 1'b1, 1'b1,
              '{KIND_READ, 8'h00, 8'h00, 8'h00, 3'd1}},
            // frame with extreme payload bytes
            '{OP_RECEIVE, HEADER_RESET, 8'h00, CSUM_KEEP, 1'b0, 1'b0, NONE_RES},
            '{OP_RECEIVE, 8'h03, 8'h00, CSUM_KEEP, 1'b0, 1'b0, NONE_RES},
            '{OP_RECEIVE, 8'hFF, 8'h00, CSUM_KEEP, 1'b0, 1'b0, NONE_RES},
            '{OP_RECEIVE, 8'h00, 8'h00, CSUM_KEEP, 1'b0, 1'b0, NONE_RES},
            '{OP_RECEIVE, 8'hFF, 8'h00, CSUM_KEEP, 1'b0, 1'b0, NONE_RES},
            '{OP_RECEIVE, 8'hAA, 8'h00, CSUM_KEEP, 1'b0, 1'b0, NONE_RES},
            '{OP_RECEIVE, 8'h00, 8'h00, CSUM_GOOD, 1'b0, 1'b0, NONE_RES},
            '{OP_READ,    8'h00, 8'h01, CSUM_KEEP, 1'b0, 1'b0, NONE_RES},
            '{OP_READ,    8'h00, 8'h00, CSUM_KEEP, 1'b0, 1'b0, NONE_RES},
            // length one, bad checksum
            '{OP_RECEIVE, HEADER_RESET, 8'h00, CSUM_KEEP, 1'b0, 1'b0, NONE_RES},
            '{OP_RECEIVE, 8'h01, 8'h00, CSUM_KEEP, 1'b0, 1'b0, NONE_RES},
            '{OP_RECEIVE, 8'h80, 8'h00, CSUM_KEEP, 1'b0, 1'b0, NONE_RES},
            '{OP_RECEIVE, 8'h55, 8'h00, CSUM_KEEP, 1'b0, 1'b0, NONE_RES},
            '{OP_RECEIVE, 8'h81, 8'h00, CSUM_KEEP, 1'b1, 1'b1,
              '{KIND_FAIL, 8'h80, 8'h01, 8'h00, 3'd2}},
            // release both packets
            '{OP_RELEASE, 8'h00, 8'h00, CSUM_KEEP, 1'b1, 1'b1,
              '{KIND_RELEASED, 8'h00, 8'h00, 8'h00, 3'd1}},
            '{OP_RELEASE, 8'h00, 8'h00, CSUM_KEEP, 1'b0, 1'b0, NONE_RES}
        };

        repeat (4) @(negedge aclk);
        aresetn <= 1'b1;

        foreach (directed_rows[i]) begin
            row = directed_rows[i];
            send_word(row.op, row.rx, row.idx, row.csum, row.typed, row.has_res, row.res);
        end

        for (phase = 0; phase < PHASES; phase++) begin
            // drain, then load a new start byte while idle
            settle_results();
            case (phase)
                0:       next_start = 8'h00;
                1:       next_start = 8'hFF;
                2:       next_start = HEADER_RESET;
                default: next_start = 8'($urandom_range(0, 255));
            endcase
            @(negedge aclk);
            cfg_data  <= next_start;
            cfg_valid <= 1'b1;
            do @(posedge aclk); while (!cfg_ready);
            start_byte = next_start;
            @(negedge aclk);
            cfg_valid <= 1'b0;

            // some phases rarely release, so the ring fills and frames drop
            release_pct = (phase % 3 == 1) ? 10 : 45;
            goal        = word_count + PHASE_WORDS;
            while (word_count < goal) begin
                if ($urandom_range(0, 39) == 0) begin
                    quiet_run = !quiet_run;
                end
                pick = $urandom_range(0, 99);
                if (pick < 60) begin
                    // build a frame: mostly short, a few near the largest length
                    len_pick = $urandom_range(0, 99);
                    if (len_pick < 90) begin
                        flen = $urandom_range(0, 8);
                    end else if (len_pick < 97) begin
                        flen = $urandom_range(9, 40);
                    end else begin
                        flen = $urandom_range(200, 255);
                    end
                    frame_bytes.delete();
                    frame_bytes.push_back(start_byte);
                    frame_bytes.push_back(8'(flen));
                    frame_bytes.push_back(8'($urandom_range(0, 255)));
                    repeat ((flen == 0) ? 0 : flen - 1) begin
                        frame_bytes.push_back(8'($urandom_range(0, 255)));
                    end
                    frame_bytes.push_back(8'($urandom_range(0, 255)));
                    // now and then cut the frame short before its checksum
                    cut = ($urandom_range(0, 19) == 0) ? $urandom_range(1, frame_bytes.size())
                                                      : frame_bytes.size() + 1;
                    for (int k = 0; k < frame_bytes.size() && k < cut; k++) begin
                        if ($urandom_range(0, 99) < 8) begin
                            send_command();
                        end
                        send_word(OP_RECEIVE, frame_bytes[k], 8'($urandom_range(0, 255)),
                                  CSUM_KEEP, 1'b0, 1'b0, NONE_RES);
                    end
                    if (cut > frame_bytes.size()) begin
                        send_word(OP_RECEIVE, 8'h00, 8'($urandom_range(0, 255)),
                                  ($urandom_range(0, 99) < 15) ? CSUM_BAD : CSUM_GOOD,
                                  1'b0, 1'b0, NONE_RES);
                    end
                end else if (pick < 85) begin
                    send_command();
                end else if (pick < 93) begin
                    // stray byte
                    send_word(OP_RECEIVE, 8'($urandom_range(0, 255)),
                              8'($urandom_range(0, 255)), CSUM_KEEP, 1'b0, 1'b0, NONE_RES);
                end else begin
                    send_word(OP_IGNORE, 8'($urandom_range(0, 255)),
                              8'($urandom_range(0, 255)), CSUM_KEEP, 1'b0, 1'b0, NONE_RES);
                end
            end
        end

        settle_results();
        if (awaited_results.size() != 0) begin
            report_mismatch($sformatf("%0d results never arrived", awaited_results.size()));
        end
        if (mismatch_count == 0) begin
            $display("All tests passed");
        end else begin
            $display("Some tests failed");
        end
        $finish;
    end

endmodule
